[rtl/mrsa_pkg.sv]
// ----------------------------------------------------------------------------
// mrsa_pkg
// Shared types and codes of the mark/release stack allocator.
// ----------------------------------------------------------------------------
package mrsa_pkg;

   // offset and usage widths
   localparam int OFFSET_WIDTH = 16;
   localparam int USAGE_WIDTH  = OFFSET_WIDTH + 1;
   localparam int STATUS_WIDTH = 3;
   localparam int CSR_WIDTH    = 32;
   localparam int ADDR_WIDTH   = 3;

   // operation codes
   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_EXIT  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DISABLED = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_ROOM  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 3'd4;

   // register index (address bit 2)
   localparam logic REG_ENABLED     = 1'b0;
   localparam logic REG_REGION_SIZE = 1'b1;

   // round-up mask for four byte alignment
   localparam int ALIGN_MASK = 3;

   typedef struct packed {
      logic                    enabled;
      logic [OFFSET_WIDTH-1:0] region_size;
      logic                    clear;
   } csr_type;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] granted_offset;
      logic                    granted;
      logic [STATUS_WIDTH-1:0] status;
      logic [USAGE_WIDTH-1:0]  usage;
      logic [OFFSET_WIDTH-1:0] peak;
   } rsp_type;

endpackage

[rtl/mrsa_csr.sv]
// ----------------------------------------------------------------------------
// mrsa_csr
// APB-style register block: enable and region size. A write of the enable
// register also clears the allocator counters.
// ----------------------------------------------------------------------------
module mrsa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                reg_index,
   input  logic [mrsa_pkg::CSR_WIDTH-1:0]      pwdata,
   output logic [mrsa_pkg::CSR_WIDTH-1:0]      prdata,
   output mrsa_pkg::csr_type                   csr
);
   import mrsa_pkg::*;

   logic                    enabled_ff, enabled_in;
   logic [OFFSET_WIDTH-1:0] region_ff, region_in;
   logic                    wr;

   // write strobe, pready is tied high
   assign wr = psel & penable & pwrite;

   always_comb begin
      enabled_in = enabled_ff;
      region_in  = region_ff;
      if (wr) begin
         unique case (reg_index)
            REG_ENABLED:     enabled_in = pwdata[0];
            REG_REGION_SIZE: region_in  = pwdata[OFFSET_WIDTH-1:0];
            default:         enabled_in = enabled_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         region_ff  <= '0;
      end else begin
         enabled_ff <= enabled_in;
         region_ff  <= region_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_ENABLED:     prdata = {{(CSR_WIDTH-1){1'b0}}, enabled_ff};
         REG_REGION_SIZE: prdata = {{(CSR_WIDTH-OFFSET_WIDTH){1'b0}}, region_ff};
         default:         prdata = '0;
      endcase
   end

   assign csr.enabled     = enabled_ff;
   assign csr.region_size = region_ff;
   assign csr.clear       = wr & (reg_index == REG_ENABLED);

endmodule

[rtl/mrsa_mark_mem.sv]
// ----------------------------------------------------------------------------
// mrsa_mark_mem
// Mark stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrsa_mark_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mrsa_exec.sv]
// ----------------------------------------------------------------------------
// mrsa_exec
// Execute stage: offset, peak and mark depth registers, the fit check and
// round-up, and the mark stack write and read addressing.
// ----------------------------------------------------------------------------
module mrsa_exec #(
   parameter int MARK_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrsa_pkg::csr_type                     csr,
   input  logic                                  fire,
   input  logic [1:0]                            op,
   input  logic [mrsa_pkg::OFFSET_WIDTH-1:0]     req,
   input  logic [mrsa_pkg::USAGE_WIDTH-1:0]      rd_data,
   output logic [$clog2(MARK_DEPTH)-1:0]         rd_addr,
   output logic                                  wr_en,
   output logic [$clog2(MARK_DEPTH)-1:0]         wr_addr,
   output logic [mrsa_pkg::USAGE_WIDTH-1:0]      wr_data,
   output mrsa_pkg::rsp_type                     result
);
   import mrsa_pkg::*;

   localparam int DW        = $clog2(MARK_DEPTH + 1);
   localparam int AW        = $clog2(MARK_DEPTH);
   localparam int END_WIDTH = USAGE_WIDTH + 1;

   logic [USAGE_WIDTH-1:0]  offset_ff, offset_in;
   logic [OFFSET_WIDTH-1:0] peak_ff, peak_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic [DW-1:0]           depth_less;
   logic [END_WIDTH-1:0]    end_sum;
   logic [END_WIDTH-1:0]    round_sum;
   logic                    fits;
   logic                    full;
   logic                    empty;
   logic [STATUS_WIDTH-1:0] status;
   logic                    granted;
   logic                    push;

   // fit check at full width and round-up to four bytes
   assign end_sum   = {1'b0, offset_ff} + {{(END_WIDTH-OFFSET_WIDTH){1'b0}}, req};
   assign fits      = end_sum <= {{(END_WIDTH-OFFSET_WIDTH){1'b0}}, csr.region_size};
   assign round_sum = (end_sum + END_WIDTH'(ALIGN_MASK)) & ~END_WIDTH'(ALIGN_MASK);

   assign full       = depth_ff >= DW'(MARK_DEPTH);
   assign empty      = depth_ff == '0;
   assign depth_less = depth_ff - DW'(1);

   // next state of one item
   always_comb begin
      offset_in = offset_ff;
      peak_in   = peak_ff;
      depth_in  = depth_ff;
      status    = STATUS_OK;
      granted   = 1'b0;
      push      = 1'b0;
      if (!csr.enabled) begin
         status = STATUS_DISABLED;
      end else begin
         unique case (op)
            OP_ENTER: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  push     = 1'b1;
                  depth_in = depth_ff + DW'(1);
               end
            end
            OP_ALLOC: begin
               if (fits) begin
                  granted   = 1'b1;
                  offset_in = round_sum[USAGE_WIDTH-1:0];
                  if (end_sum > {{(END_WIDTH-OFFSET_WIDTH){1'b0}}, peak_ff}) begin
                     peak_in = end_sum[OFFSET_WIDTH-1:0];
                  end
               end else begin
                  status = STATUS_NO_ROOM;
               end
            end
            OP_EXIT: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  depth_in  = depth_less;
                  offset_in = rd_data;
               end
            end
            OP_NOP: status = STATUS_OK;
            default: status = STATUS_OK;
         endcase
      end
   end

   // state registers, enable write clears them
   always_ff @(posedge clock) begin
      if (reset || csr.clear) begin
         offset_ff <= '0;
         peak_ff   <= '0;
         depth_ff  <= '0;
      end else if (fire) begin
         offset_ff <= offset_in;
         peak_ff   <= peak_in;
         depth_ff  <= depth_in;
      end
   end

   // mark stack addressing: push writes at depth, pop reads depth - 1
   assign wr_en   = fire & push;
   assign wr_addr = depth_ff[AW-1:0];
   assign wr_data = offset_ff;
   assign rd_addr = depth_less[AW-1:0];

   assign result.granted_offset = granted ? offset_ff[OFFSET_WIDTH-1:0] : '0;
   assign result.granted        = granted;
   assign result.status         = status;
   assign result.usage          = offset_in;
   assign result.peak           = peak_in;

endmodule

[rtl/mark_release_stack_allocator.sv]
// ----------------------------------------------------------------------------
// mark_release_stack_allocator
// Bump allocator over a configured region with a stack of saved marks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries an operation (enter,
//   alloc, exit) and a byte count; each item yields exactly one result on
//   the response channel (rsp_valid / rsp_stall).
//   The accepting edge also issues the mark stack memory read. In the
//   next cycle the read data is valid; the item executes once the output
//   register is free, and its result is loaded into that register, which
//   drives rsp_valid. The execute slot frees on the edge that loads the
//   result, and only after that can the next item be accepted; no item is
//   accepted while another one is in execute.
//   req_stall is high while an item sits in the execute stage. If the
//   receiver stalls, the result waits in the output register; one more
//   item may be accepted and waits in execute until the register frees.
//   Reset clears the enable and region size registers, the offset, peak
//   and mark depth; mark stack contents are not cleared (entries are
//   only read after being pushed). Writing the enable register clears
//   offset, peak and mark depth. Configure only while idle.
// ----------------------------------------------------------------------------
module mark_release_stack_allocator #(
   parameter int MARK_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic [mrsa_pkg::OFFSET_WIDTH-1:0]    req_request_bytes,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mrsa_pkg::OFFSET_WIDTH-1:0]    rsp_granted_offset,
   output logic                                 rsp_granted,
   output logic [mrsa_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [mrsa_pkg::USAGE_WIDTH-1:0]     rsp_usage,
   output logic [mrsa_pkg::OFFSET_WIDTH-1:0]    rsp_peak,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mrsa_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [mrsa_pkg::CSR_WIDTH-1:0]       pwdata,
   output logic [mrsa_pkg::CSR_WIDTH-1:0]       prdata,
   output logic                                 pready
);
   import mrsa_pkg::*;

   localparam int AW = $clog2(MARK_DEPTH);

   csr_type                 csr;
   logic                    busy_ff, busy_in;
   logic [1:0]              op_ff;
   logic [OFFSET_WIDTH-1:0] req_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 result;
   logic                    accept;
   logic                    fire;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic                    wr_en;
   logic [USAGE_WIDTH-1:0]  wr_data;
   logic [USAGE_WIDTH-1:0]  rd_data;

   assign pready = 1'b1;

   mrsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .reg_index (paddr[2]),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .csr       (csr)
   );

   // handshake: one item in execute at a time
   assign req_stall    = busy_ff;
   assign accept       = req_valid & ~busy_ff;
   assign fire         = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign busy_in      = accept | (busy_ff & ~fire);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         req_ff <= req_request_bytes;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   mrsa_mark_mem #(
      .DEPTH (MARK_DEPTH),
      .AW    (AW),
      .WIDTH (USAGE_WIDTH)
   ) u_mark_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mrsa_exec #(
      .MARK_DEPTH (MARK_DEPTH)
   ) u_exec (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .fire    (fire),
      .op      (op_ff),
      .req     (req_ff),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .result  (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_ff.granted_offset;
   assign rsp_granted        = rsp_ff.granted;
   assign rsp_status         = rsp_ff.status;
   assign rsp_usage          = rsp_ff.usage;
   assign rsp_peak           = rsp_ff.peak;

endmodule

[rtl/mrsa_checker.sv]
// ----------------------------------------------------------------------------
// mrsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mrsa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [mrsa_pkg::OFFSET_WIDTH-1:0]    rsp_granted_offset,
   input logic                                 rsp_granted,
   input logic [mrsa_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input logic [mrsa_pkg::USAGE_WIDTH-1:0]     rsp_usage,
   input logic [mrsa_pkg::OFFSET_WIDTH-1:0]    rsp_peak
);
   import mrsa_pkg::*;

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_usage) && $stable(rsp_status)
         && $stable(rsp_granted_offset) && $stable(rsp_peak))
      else $error("stalled result changed");

   // a grant always reports ok, a refusal carries no offset
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_granted ? rsp_status == STATUS_OK : rsp_granted_offset == '0))
      else $error("grant and status disagree");

   // usage stays four byte aligned
   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_usage[1:0] == 2'b00)
      else $error("usage not aligned");

   // a granted chunk lies below both usage and the peak
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |->
         {1'b0, rsp_granted_offset} <= rsp_usage && rsp_granted_offset <= rsp_peak)
      else $error("granted offset beyond usage or peak");

endmodule

bind mark_release_stack_allocator mrsa_checker u_mrsa_checker (.*);

[dv/mark_release_stack_allocator_tb.sv]
// ----------------------------------------------------------------------------
// mark_release_stack_allocator_tb
// Checks every result of the mark/release allocator against a local
// prediction. A short directed part covers the refusal codes, the alignment
// corner at the top of the region and the shrink under a live offset. Random
// nested frames, deep mark stack runs and raw noise follow, under three
// patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mark_release_stack_allocator_tb;
   import mrsa_pkg::*;

   localparam int MARKS       = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_operation;
   logic [OFFSET_WIDTH-1:0] req_request_bytes;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [OFFSET_WIDTH-1:0] rsp_granted_offset;
   logic                    rsp_granted;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [USAGE_WIDTH-1:0]  rsp_usage;
   logic [OFFSET_WIDTH-1:0] rsp_peak;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [ADDR_WIDTH-1:0]   paddr;
   logic [CSR_WIDTH-1:0]    pwdata;
   logic [CSR_WIDTH-1:0]    prdata;
   logic                    pready;

   mark_release_stack_allocator #(
      .MARK_DEPTH(MARKS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_request_bytes  (req_request_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted        (rsp_granted),
      .rsp_status         (rsp_status),
      .rsp_usage          (rsp_usage),
      .rsp_peak           (rsp_peak),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // allocator shadow: registers, offset, peak and saved marks
   logic                    shadow_enabled;
   logic [OFFSET_WIDTH-1:0] shadow_region;
   logic [USAGE_WIDTH-1:0]  shadow_offset;
   logic [OFFSET_WIDTH-1:0] shadow_peak;
   int                      shadow_depth;
   logic [USAGE_WIDTH-1:0]  shadow_marks [MARKS];

   rsp_type pending_results[$];
   rsp_type oldest_result;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int items_sent;
   int results_seen;
   int grants_seen;
   int status_hits [8];
   int cycle_count;

   // register write side effects; enable writes clear the counters
   function automatic void shadow_write_reg(input logic idx, input logic [CSR_WIDTH-1:0] data);
      if (idx == REG_ENABLED) begin
         shadow_enabled = data[0];
         shadow_offset  = '0;
         shadow_peak    = '0;
         shadow_depth   = 0;
      end else begin
         shadow_region = data[OFFSET_WIDTH-1:0];
      end
   endfunction

   // expected result of one item, advancing the shadow state
   function automatic rsp_type predict_allocation(input logic [1:0] op,
                                                  input logic [OFFSET_WIDTH-1:0] bytes);
      rsp_type              r;
      logic [USAGE_WIDTH:0] chunk_end;
      logic [USAGE_WIDTH:0] rounded;
      r = '0;
      r.status = STATUS_OK;
      if (!shadow_enabled) begin
         r.status = STATUS_DISABLED;
      end else begin
         case (op)
            OP_ENTER: begin
               if (shadow_depth >= MARKS) begin
                  r.status = STATUS_FULL;
               end else begin
                  shadow_marks[shadow_depth] = shadow_offset;
                  shadow_depth++;
               end
            end
            OP_ALLOC: begin
               // full width compare: an offset past a shrunk region never fits
               chunk_end = {1'b0, shadow_offset} + bytes;
               if (chunk_end <= shadow_region) begin
                  r.granted_offset = shadow_offset[OFFSET_WIDTH-1:0];
                  r.granted        = 1'b1;
                  if (chunk_end > shadow_peak) shadow_peak = chunk_end[OFFSET_WIDTH-1:0];
                  rounded       = chunk_end + (USAGE_WIDTH+1)'(ALIGN_MASK);
                  shadow_offset = rounded[USAGE_WIDTH-1:0] & ~USAGE_WIDTH'(ALIGN_MASK);
               end else begin
                  r.status = STATUS_NO_ROOM;
               end
            end
            OP_EXIT: begin
               if (shadow_depth == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  shadow_depth--;
                  shadow_offset = shadow_marks[shadow_depth];
               end
            end
            default: ;
         endcase
      end
      r.usage = shadow_offset;
      r.peak  = shadow_peak;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", results_seen, what, got, want);
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_granted_offset !== oldest_result.granted_offset)
               report_mismatch("granted_offset", rsp_granted_offset, oldest_result.granted_offset);
            if (rsp_granted !== oldest_result.granted)
               report_mismatch("granted", rsp_granted, oldest_result.granted);
            if (rsp_status !== oldest_result.status)
               report_mismatch("status", rsp_status, oldest_result.status);
            if (rsp_usage !== oldest_result.usage)
               report_mismatch("usage", rsp_usage, oldest_result.usage);
            if (rsp_peak !== oldest_result.peak)
               report_mismatch("peak", rsp_peak, oldest_result.peak);
         end
         results_seen++;
         if (rsp_granted === 1'b1) grants_seen++;
         if (!$isunknown(rsp_status)) status_hits[rsp_status]++;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit, %0d results outstanding",
                  pending_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // send one item; valid stays high into the next item unless it idles
   task automatic send_item(input logic [1:0] op, input logic [OFFSET_WIDTH-1:0] bytes);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_request_bytes <= bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_allocation(op, bytes));
      items_sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_WIDTH-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      shadow_write_reg(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic idx, output logic [CSR_WIDTH-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // idle, write both registers, read them back
   task automatic configure(input logic en, input logic [OFFSET_WIDTH-1:0] region);
      logic [CSR_WIDTH-1:0] readback;
      drain();
      csr_write(REG_REGION_SIZE, CSR_WIDTH'(region));
      csr_write(REG_ENABLED, CSR_WIDTH'(en));
      csr_read(REG_REGION_SIZE, readback);
      if (readback[OFFSET_WIDTH-1:0] !== region)
         report_mismatch("region_size readback", readback, region);
      csr_read(REG_ENABLED, readback);
      if (readback[0] !== en)
         report_mismatch("enabled readback", readback, en);
   endtask

   // mostly small requests, some scaled to the region, a few full range
   function automatic logic [OFFSET_WIDTH-1:0] pick_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return OFFSET_WIDTH'($urandom_range(0, 40));
      if (r < 85) return OFFSET_WIDTH'($urandom_range(0, shadow_region / 4));
      return OFFSET_WIDTH'($urandom_range(0, 65535));
   endfunction

   // refusals, the top of the region, rounding past the end, shrink
   task automatic test_directed();
      send_item(OP_ENTER, 16'h0000);
      send_item(OP_ALLOC, 16'hFFFF);
      send_item(OP_EXIT, 16'h0000);
      send_item(OP_NOP, 16'hFFFF);
      configure(1'b1, 16'hFFFF);
      send_item(OP_EXIT, 16'h0000);
      send_item(OP_ALLOC, 16'hFFFF);
      send_item(OP_ALLOC, 16'h0000);
      send_item(OP_NOP, 16'h5555);
      send_item(OP_ENTER, 16'hAAAA);
      send_item(OP_EXIT, 16'h0000);
      configure(1'b1, 16'd10);
      send_item(OP_ENTER, 16'h0000);
      send_item(OP_ALLOC, 16'd3);
      send_item(OP_ALLOC, 16'd7);
      send_item(OP_ALLOC, 16'd6);
      send_item(OP_EXIT, 16'h0000);
      send_item(OP_ALLOC, 16'd0);
      configure(1'b1, 16'd1000);
      send_item(OP_ALLOC, 16'd500);
      // shrink the region under a live offset
      drain();
      csr_write(REG_REGION_SIZE, 32'd100);
      send_item(OP_ALLOC, 16'd0);
      send_item(OP_EXIT, 16'h0000);
      configure(1'b1, 16'd0);
      send_item(OP_ALLOC, 16'd0);
      send_item(OP_ALLOC, 16'd1);
   endtask

   // well-formed nested frames with random request sizes
   task automatic test_nested_frames(input logic [OFFSET_WIDTH-1:0] region, input int count);
      int r;
      configure(1'b1, region);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (shadow_depth == 0 && r < 40)
            send_item(OP_ENTER, OFFSET_WIDTH'($urandom_range(0, 65535)));
         else if (r < 20 && shadow_depth < MARKS - 1)
            send_item(OP_ENTER, OFFSET_WIDTH'($urandom_range(0, 65535)));
         else if (r < 70 || shadow_depth == 0)
            send_item(OP_ALLOC, pick_bytes());
         else
            send_item(OP_EXIT, OFFSET_WIDTH'($urandom_range(0, 65535)));
      end
   endtask

   // push up to or past a full mark stack, then pop past an empty one
   task automatic test_mark_stack_limits();
      int levels;
      configure(1'b1, OFFSET_WIDTH'($urandom_range(256, 65535)));
      levels = $urandom_range(MARKS - 1, MARKS + 2);
      repeat (levels) begin
         send_item(OP_ENTER, OFFSET_WIDTH'($urandom_range(0, 65535)));
         if ($urandom_range(0, 1)) send_item(OP_ALLOC, pick_bytes());
      end
      repeat (levels + 2) begin
         send_item(OP_EXIT, OFFSET_WIDTH'($urandom_range(0, 65535)));
         if ($urandom_range(0, 3) == 0) send_item(OP_ALLOC, pick_bytes());
      end
   endtask

   // any operation code, any byte count
   task automatic test_noise(input logic en, input logic [OFFSET_WIDTH-1:0] region,
                             input int count);
      configure(en, region);
      repeat (count)
         send_item(2'($urandom_range(0, 3)), OFFSET_WIDTH'($urandom_range(0, 65535)));
   endtask

   // allocate, then cut the region to at or below the offset without a clear
   task automatic test_region_shrink();
      configure(1'b1, OFFSET_WIDTH'($urandom_range(200, 4000)));
      repeat (30) begin
         if ($urandom_range(0, 4) == 0) send_item(OP_ENTER, 16'h0000);
         else send_item(OP_ALLOC, OFFSET_WIDTH'($urandom_range(0, 60)));
      end
      drain();
      csr_write(REG_REGION_SIZE, CSR_WIDTH'($urandom_range(0, shadow_offset)));
      repeat (20)
         send_item(2'($urandom_range(0, 3)), OFFSET_WIDTH'($urandom_range(0, 64)));
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_ENTER;
      req_request_bytes = '0;
      rsp_stall         = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      mismatches        = 0;
      items_sent        = 0;
      results_seen      = 0;
      grants_seen       = 0;
      cycle_count       = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      shadow_write_reg(REG_REGION_SIZE, '0);
      shadow_write_reg(REG_ENABLED, '0);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles often, receiver stalls more
      send_idle_pct = 37;
      recv_idle_pct = 71;
      test_directed();
      test_nested_frames(16'd4096, 250);
      test_mark_stack_limits();
      test_mark_stack_limits();
      test_noise(1'b1, OFFSET_WIDTH'($urandom_range(0, 65535)), 80);
      test_region_shrink();

      // the other way round
      send_idle_pct = 71;
      recv_idle_pct = 37;
      test_nested_frames(16'hFFFF, 250);
      test_mark_stack_limits();
      test_noise(1'b1, 16'd0, 60);
      test_noise(1'b0, OFFSET_WIDTH'($urandom_range(0, 65535)), 40);

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_nested_frames(16'd255, 250);
      test_mark_stack_limits();
      test_noise(1'b1, 16'hFFFF, 80);
      test_region_shrink();

      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d items and %0d results, %0d of them grants", items_sent,
               results_seen, grants_seen);
      $display("Statuses: ok %0d, disabled %0d, no room %0d, stack full %0d, stack empty %0d",
               status_hits[STATUS_OK], status_hits[STATUS_DISABLED], status_hits[STATUS_NO_ROOM],
               status_hits[STATUS_FULL], status_hits[STATUS_EMPTY]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/mrsa_pkg.sv
rtl/mrsa_csr.sv
rtl/mrsa_mark_mem.sv
rtl/mrsa_exec.sv
rtl/mark_release_stack_allocator.sv
rtl/mrsa_checker.sv
dv/mark_release_stack_allocator_tb.sv
